[sv/gmps_pkg.sv]
// Shared constants, codes and types of the grid maze path search block.
// No dependencies; every other file imports this package.
package gmps_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int CELL_TOTAL = MAX_ROWS * MAX_COLS;

  localparam int ROW_W  = $clog2(MAX_ROWS);        // row index
  localparam int COL_W  = $clog2(MAX_COLS);        // column index
  localparam int NROW_W = $clog2(MAX_ROWS + 1);    // row count 1..MAX_ROWS
  localparam int NCOL_W = $clog2(MAX_COLS + 1);    // column count 1..MAX_COLS
  localparam int IDX_W  = $clog2(CELL_TOTAL);      // cell index
  localparam int NUM_W  = $clog2(CELL_TOTAL + 1);  // cell count 0..CELL_TOTAL

  localparam int SIZE_W      = 7;
  localparam int DIR_W       = 8;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int MOVES_W     = 12;
  localparam int MOVES_LIMIT = 4095;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROW_COUNT       = 2'd0,
    REG_COL_COUNT       = 2'd1,
    REG_DIRECTION_ORDER = 2'd2,
    REG_USE_QUEUE       = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLS_FREE  = 2'd0,
    CLS_WALL  = 2'd1,
    CLS_ENTRY = 2'd2,
    CLS_EXIT  = 2'd3
  } cell_cls_t;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_UP    = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  // Saturated grid size and search options
  typedef struct packed {
    logic [NROW_W-1:0] rows;
    logic [NCOL_W-1:0] cols;
    logic [DIR_W-1:0]  dir_order;
    logic              use_queue;
  } gmps_cfg_t;

  typedef struct packed {
    logic               found;
    logic [MOVES_W-1:0] moves;
  } gmps_res_t;

endpackage

[sv/gmps_search.sv]
// Search engine: cell memory (class, seen flag, parent direction) and work list memory,
// with the load, clear, search and walk-back sequencer. Depends on gmps_pkg.
module gmps_search (
  input  logic                clk,
  input  logic                rst_n,
  input  gmps_pkg::gmps_cfg_t cfg,
  input  logic                item_valid,
  input  logic                item_op,
  input  logic [1:0]          item_cls,
  output logic                idle,
  output logic                res_valid,
  input  logic                res_ready,
  output gmps_pkg::gmps_res_t res
);
  import gmps_pkg::*;

  typedef struct packed {
    cell_cls_t cls;
    logic      seen;
    dir_t      par;
  } cell_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } work_word_t;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_DIV  = 10'b0000000010,
    ST_CLR  = 10'b0000000100,
    ST_POP  = 10'b0000001000,
    ST_CUR  = 10'b0000010000,
    ST_NB   = 10'b0000100000,
    ST_NBEV = 10'b0001000000,
    ST_WLKA = 10'b0010000000,
    ST_WLKB = 10'b0100000000,
    ST_FIN  = 10'b1000000000
  } state_t;

  localparam int PROD_W = ROW_W + NCOL_W;

  function automatic logic [IDX_W-1:0] cell_index(input logic [ROW_W-1:0]  r,
                                                  input logic [COL_W-1:0]  c,
                                                  input logic [NCOL_W-1:0] cols);
    logic [PROD_W:0] prod;
    prod = (PROD_W+1)'(PROD_W'(r) * PROD_W'(cols)) + (PROD_W+1)'(c);
    return prod[IDX_W-1:0];
  endfunction

  // Memories
  cell_word_t cell_mem [CELL_TOTAL];
  work_word_t work_mem [CELL_TOTAL];
  cell_word_t cell_rd_r;
  work_word_t work_rd_r;

  logic              cell_we;
  logic [IDX_W-1:0]  cell_waddr, cell_raddr;
  cell_word_t        cell_wdata;
  logic              work_we;
  logic [IDX_W-1:0]  work_waddr, work_raddr;
  work_word_t        work_wdata;

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rd_r <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    work_rd_r <= work_mem[work_raddr];
  end

  // Control and datapath registers
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  load_pos_r, load_pos_nxt;
  logic [IDX_W-1:0]  entry_pos_r, entry_pos_nxt;
  logic              entry_none_r, entry_none_nxt;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [1:0]        dir_i_r, dir_i_nxt;
  logic [ROW_W-1:0]  nb_row_r, nb_row_nxt;
  logic [COL_W-1:0]  nb_col_r, nb_col_nxt;
  dir_t              nb_dir_r, nb_dir_nxt;
  logic [IDX_W-1:0]  nb_idx_r, nb_idx_nxt;
  logic [NUM_W-1:0]  head_r, head_nxt;
  logic [NUM_W-1:0]  tail_r, tail_nxt;
  logic [NUM_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic              clr_pend_r, clr_pend_nxt;
  logic [IDX_W-1:0]  clr_waddr_r, clr_waddr_nxt;
  logic [NUM_W-1:0]  cnt_r, cnt_nxt;
  gmps_res_t         res_r, res_nxt;

  logic [NUM_W-1:0]  cells_n;
  logic [IDX_W-1:0]  load_pos_eff;
  logic              load_none_eff;
  logic [NUM_W-1:0]  load_pos_inc;
  logic [NCOL_W-1:0] col_p1;
  logic [NROW_W-1:0] row_p1;
  dir_t              cand_dir;
  logic              cand_ok;
  logic [ROW_W-1:0]  cand_row;
  logic [COL_W-1:0]  cand_col;
  logic [IDX_W-1:0]  cand_idx;
  logic [IDX_W-1:0]  walk_idx;
  logic              nb_seen;
  logic [MOVES_W-1:0] moves_sat;

  assign cells_n = NUM_W'((NROW_W+NCOL_W)'(cfg.rows) * (NROW_W+NCOL_W)'(cfg.cols));

  assign load_pos_eff  = (NUM_W'(load_pos_r) >= cells_n) ? '0 : load_pos_r;
  assign load_none_eff = entry_none_r || (load_pos_eff == '0);
  assign load_pos_inc  = NUM_W'(load_pos_eff) + NUM_W'(1);

  assign col_p1 = NCOL_W'(col_r) + NCOL_W'(1);
  assign row_p1 = NROW_W'(row_r) + NROW_W'(1);

  // Neighbor in the direction under test
  always_comb begin
    cand_dir = dir_t'(cfg.dir_order[{dir_i_r, 1'b0} +: 2]);
    cand_ok  = 1'b0;
    cand_row = row_r;
    cand_col = col_r;
    unique case (cand_dir)
      DIR_RIGHT: begin
        cand_ok  = col_p1 < cfg.cols;
        cand_col = COL_W'(col_p1);
      end
      DIR_UP: begin
        cand_ok  = row_r != '0;
        cand_row = row_r - ROW_W'(1);
      end
      DIR_LEFT: begin
        cand_ok  = col_r != '0;
        cand_col = col_r - COL_W'(1);
      end
      DIR_DOWN: begin
        cand_ok  = row_p1 < cfg.rows;
        cand_row = ROW_W'(row_p1);
      end
      default: cand_ok = 1'b0;
    endcase
  end

  assign cand_idx  = cell_index(cand_row, cand_col, cfg.cols);
  assign walk_idx  = cell_index(row_r, col_r, cfg.cols);
  // The entry cell is seen from the start without a memory write
  assign nb_seen   = cell_rd_r.seen || (nb_idx_r == entry_pos_r);
  assign moves_sat = (32'(cnt_r) > MOVES_LIMIT) ? '1 : MOVES_W'(cnt_r);

  always_comb begin
    state_nxt      = state_r;
    load_pos_nxt   = load_pos_r;
    entry_pos_nxt  = entry_pos_r;
    entry_none_nxt = entry_none_r;
    rem_nxt        = rem_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    dir_i_nxt      = dir_i_r;
    nb_row_nxt     = nb_row_r;
    nb_col_nxt     = nb_col_r;
    nb_dir_nxt     = nb_dir_r;
    nb_idx_nxt     = nb_idx_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_pend_nxt   = clr_pend_r;
    clr_waddr_nxt  = clr_waddr_r;
    cnt_nxt        = cnt_r;
    res_nxt        = res_r;
    cell_we        = 1'b0;
    cell_waddr     = '0;
    cell_wdata     = '0;
    cell_raddr     = '0;
    work_we        = 1'b0;
    work_waddr     = '0;
    work_wdata     = '0;
    work_raddr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (item_valid && (item_op == OP_LOAD)) begin
          cell_we    = 1'b1;
          cell_waddr = load_pos_eff;
          cell_wdata = '{cls: cell_cls_t'(item_cls), seen: 1'b0, par: DIR_RIGHT};
          if ((cell_cls_t'(item_cls) == CLS_ENTRY) && load_none_eff) begin
            entry_pos_nxt  = load_pos_eff;
            entry_none_nxt = 1'b0;
          end else begin
            entry_none_nxt = load_none_eff;
          end
          load_pos_nxt = (load_pos_inc >= cells_n) ? '0 : IDX_W'(load_pos_inc);
        end else if (item_valid) begin
          if (entry_none_r || (NUM_W'(entry_pos_r) >= cells_n)) begin
            res_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            rem_nxt   = entry_pos_r;
            row_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end

      // Split the entry index into row and column by repeated subtraction
      ST_DIV: begin
        if (rem_r >= IDX_W'(cfg.cols)) begin
          rem_nxt = rem_r - IDX_W'(cfg.cols);
          row_nxt = row_r + ROW_W'(1);
        end else begin
          col_nxt      = COL_W'(rem_r);
          work_we      = 1'b1;
          work_waddr   = '0;
          work_wdata   = '{row: row_r, col: COL_W'(rem_r)};
          head_nxt     = '0;
          tail_nxt     = NUM_W'(1);
          clr_cnt_nxt  = '0;
          clr_pend_nxt = 1'b0;
          state_nxt    = ST_CLR;
        end
      end

      // Read each cell and write it back with the seen flag dropped and the parent direction reset
      ST_CLR: begin
        cell_raddr = clr_cnt_r[IDX_W-1:0];
        if (clr_pend_r) begin
          cell_we    = 1'b1;
          cell_waddr = clr_waddr_r;
          cell_wdata = '{cls: cell_rd_r.cls, seen: 1'b0, par: DIR_RIGHT};
        end
        if (clr_cnt_r < cells_n) begin
          clr_cnt_nxt   = clr_cnt_r + NUM_W'(1);
          clr_pend_nxt  = 1'b1;
          clr_waddr_nxt = clr_cnt_r[IDX_W-1:0];
        end else begin
          clr_pend_nxt = 1'b0;
          if (!clr_pend_r) begin
            state_nxt = ST_POP;
          end
        end
      end

      ST_POP: begin
        if (cfg.use_queue) begin
          work_raddr = head_r[IDX_W-1:0];
          if (head_r >= tail_r) begin
            res_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            head_nxt  = head_r + NUM_W'(1);
            state_nxt = ST_CUR;
          end
        end else begin
          work_raddr = IDX_W'(tail_r - NUM_W'(1));
          if (tail_r == '0) begin
            res_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            tail_nxt  = tail_r - NUM_W'(1);
            state_nxt = ST_CUR;
          end
        end
      end

      ST_CUR: begin
        row_nxt   = work_rd_r.row;
        col_nxt   = work_rd_r.col;
        dir_i_nxt = '0;
        state_nxt = ST_NB;
      end

      ST_NB: begin
        cell_raddr = cand_idx;
        if (cand_ok) begin
          nb_row_nxt = cand_row;
          nb_col_nxt = cand_col;
          nb_dir_nxt = cand_dir;
          nb_idx_nxt = cand_idx;
          state_nxt  = ST_NBEV;
        end else begin
          dir_i_nxt = dir_i_r + 2'd1;
          state_nxt = (&dir_i_r) ? ST_POP : ST_NB;
        end
      end

      // Neighbor word is back: mark it, push it or finish on an exit
      ST_NBEV: begin
        dir_i_nxt = dir_i_r + 2'd1;
        state_nxt = (&dir_i_r) ? ST_POP : ST_NB;
        if (!nb_seen) begin
          cell_we    = 1'b1;
          cell_waddr = nb_idx_r;
          cell_wdata = '{cls: cell_rd_r.cls, seen: 1'b1, par: nb_dir_r};
          if (cell_rd_r.cls == CLS_EXIT) begin
            row_nxt   = nb_row_r;
            col_nxt   = nb_col_r;
            cnt_nxt   = '0;
            state_nxt = ST_WLKA;
          end else if ((cell_rd_r.cls == CLS_FREE) && (tail_r < NUM_W'(CELL_TOTAL))) begin
            work_we    = 1'b1;
            work_waddr = tail_r[IDX_W-1:0];
            work_wdata = '{row: nb_row_r, col: nb_col_r};
            tail_nxt   = tail_r + NUM_W'(1);
          end
        end
      end

      ST_WLKA: begin
        cell_raddr = walk_idx;
        if ((walk_idx == entry_pos_r) || (cnt_r >= cells_n)) begin
          res_nxt   = '{found: 1'b1, moves: moves_sat};
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_WLKB;
        end
      end

      // Step back against the parent direction, stop at the grid edge
      ST_WLKB: begin
        state_nxt = ST_WLKA;
        cnt_nxt   = cnt_r + NUM_W'(1);
        unique case (cell_rd_r.par)
          DIR_RIGHT: begin
            if (col_r == '0) begin
              cnt_nxt   = cnt_r;
              state_nxt = ST_FIN;
            end else begin
              col_nxt = col_r - COL_W'(1);
            end
          end
          DIR_UP: begin
            if (row_p1 >= cfg.rows) begin
              cnt_nxt   = cnt_r;
              state_nxt = ST_FIN;
            end else begin
              row_nxt = ROW_W'(row_p1);
            end
          end
          DIR_LEFT: begin
            if (col_p1 >= cfg.cols) begin
              cnt_nxt   = cnt_r;
              state_nxt = ST_FIN;
            end else begin
              col_nxt = COL_W'(col_p1);
            end
          end
          DIR_DOWN: begin
            if (row_r == '0) begin
              cnt_nxt   = cnt_r;
              state_nxt = ST_FIN;
            end else begin
              row_nxt = row_r - ROW_W'(1);
            end
          end
          default: state_nxt = ST_FIN;
        endcase
        if (state_nxt == ST_FIN) begin
          res_nxt = '{found: 1'b1, moves: moves_sat};
        end
      end

      ST_FIN: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      load_pos_r   <= '0;
      entry_pos_r  <= '0;
      entry_none_r <= 1'b1;
      head_r       <= '0;
      tail_r       <= '0;
      clr_cnt_r    <= '0;
      clr_pend_r   <= 1'b0;
      dir_i_r      <= '0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      load_pos_r   <= load_pos_nxt;
      entry_pos_r  <= entry_pos_nxt;
      entry_none_r <= entry_none_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_pend_r   <= clr_pend_nxt;
      dir_i_r      <= dir_i_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    nb_row_r    <= nb_row_nxt;
    nb_col_r    <= nb_col_nxt;
    nb_dir_r    <= nb_dir_nxt;
    nb_idx_r    <= nb_idx_nxt;
    clr_waddr_r <= clr_waddr_nxt;
    res_r       <= res_nxt;
  end

  assign idle      = state_r == ST_IDLE;
  assign res_valid = state_r == ST_FIN;
  assign res       = res_r;

endmodule

[sv/grid_maze_path_search.sv]
// Top level of the grid maze path search: configuration registers, stream ports and
// output register around the search engine. Depends on gmps_pkg and gmps_search.
//
//   channel   dir  tdata                         tuser
//   in_       in   [1:0] cell_class              op (0 load cell, 1 search)
//   out_      out  [0] found, [12:1] moves       -
//   cfg_      in   write enable, index, data     -
//
// A load beat makes one write to the cell memory; loads go back to back while the engine
// is idle. A search beat holds in_tready low through the row split of the entry index, a
// clear pass over the cell memory, then per work list entry a pop and a check of each
// direction with a read of each in-grid neighbor, then the walk back along the path (or
// the final empty pop on a miss), then the hand-off, longer while the output register
// stays full. With no usable entry only the hand-off remains.
// The cell memory has a single read port.
// rst_n clears control state only; the maze contents survive and are not cleared.
// A result waiting in the output register does not block loads; a second result waits in
// the engine until the register frees.
module grid_maze_path_search (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [gmps_pkg::IN_TDATA_W-1:0]    in_tdata,   // [1:0] cell_class
  input  logic                               in_tuser,   // [0] op
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [gmps_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [0] found, [12:1] moves
  input  logic                               cfg_we,
  input  logic [gmps_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [gmps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import gmps_pkg::*;

  logic [SIZE_W-1:0] row_count_r;
  logic [SIZE_W-1:0] col_count_r;
  logic [DIR_W-1:0]  dir_order_r;
  logic              use_queue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= SIZE_W'(64);
      col_count_r <= SIZE_W'(64);
      dir_order_r <= DIR_W'(228);
      use_queue_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ROW_COUNT:       row_count_r <= cfg_wdata[SIZE_W-1:0];
        REG_COL_COUNT:       col_count_r <= cfg_wdata[SIZE_W-1:0];
        REG_DIRECTION_ORDER: dir_order_r <= cfg_wdata[DIR_W-1:0];
        REG_USE_QUEUE:       use_queue_r <= cfg_wdata[0];
        default:             use_queue_r <= use_queue_r;
      endcase
    end
  end

  // Saturate the grid size to 1..MAX
  gmps_cfg_t cfg;
  always_comb begin
    if (row_count_r == '0) begin
      cfg.rows = NROW_W'(1);
    end else if (32'(row_count_r) > MAX_ROWS) begin
      cfg.rows = NROW_W'(MAX_ROWS);
    end else begin
      cfg.rows = NROW_W'(row_count_r);
    end
    if (col_count_r == '0) begin
      cfg.cols = NCOL_W'(1);
    end else if (32'(col_count_r) > MAX_COLS) begin
      cfg.cols = NCOL_W'(MAX_COLS);
    end else begin
      cfg.cols = NCOL_W'(col_count_r);
    end
    cfg.dir_order = dir_order_r;
    cfg.use_queue = use_queue_r;
  end

  logic      eng_idle;
  logic      res_valid;
  logic      res_ready;
  gmps_res_t res;
  logic      out_tvalid_r;
  gmps_res_t out_res_r;

  assign in_tready = eng_idle;
  assign res_ready = !out_tvalid_r || out_tready;

  gmps_search u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (in_tvalid && in_tready),
    .item_op    (in_tuser),
    .item_cls   (in_tdata[1:0]),
    .idle       (eng_idle),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_TDATA_W - MOVES_W - 1)'(0), out_res_r.moves, out_res_r.found};

endmodule

[sv/gmps_check.sv]
// Port-level checker for grid_maze_path_search, attached by the bind at the end.
// Depends on gmps_pkg.
module gmps_check (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [gmps_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import gmps_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // A miss always reports zero moves
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[MOVES_W:1] == '0)
    else $error("miss with nonzero moves");

  // A load beat never makes a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_LOAD) && !out_tvalid |=> !out_tvalid)
    else $error("result after a load beat");

  // A search beat drops the input ready in the cycle after it is taken
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_SEARCH) |=> !in_tready)
    else $error("input ready right after a search beat");

endmodule

bind grid_maze_path_search gmps_check u_gmps_check (.*);
